// ===== src/rocu_pkg.sv =====
`timescale 1ns / 1ps

package rocu_pkg;

   localparam int DEF_MAX_SLABS = 1024;

   localparam int FUNC_W      = 3;
   localparam int SLAB_W      = 12;
   localparam int SLAB_OUT_W  = 10;
   localparam int BEGIN_W     = 13;
   localparam int REPORT_W    = 11;
   localparam int ACTION_W    = 16;
   localparam int SC_W        = 11;
   localparam int START_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [REPORT_W-1:0] REPORT_MAX = '1;
   localparam logic [ACTION_W-1:0] ACTION_MAX = '1;

   localparam int RESET_SLAB_COUNT     = 1024;
   localparam int RESET_START_SLAB     = 0;
   localparam int RESET_EXPECTED_TOTAL = 1024;

   typedef enum logic [FUNC_W-1:0] {
      FN_ATTEMPT = 3'd0,
      FN_QUERY   = 3'd1,
      FN_MARK    = 3'd2,
      FN_FORCE   = 3'd3,
      FN_RESTART = 3'd4
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLAB_COUNT     = 2'd0,
      CSR_START_SLAB     = 2'd1,
      CSR_EXPECTED_TOTAL = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LP_WAIT,
      ST_ATT_RD,
      ST_ATT_CHK,
      ST_WS_WAIT,
      ST_Q_RD,
      ST_Q_DONE,
      ST_Q_B0_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_M_WR,
      ST_R_WAIT,
      ST_RCLEAR,
      ST_RESP
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_RUN,
      MS_FIX
   } mod_state_type;

   typedef enum logic [1:0] {
      SRC_LP,
      SRC_SLAB,
      SRC_SLAB_M1,
      SRC_START_M1
   } mod_src_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_RD_WS,
      MEM_RD_WB,
      MEM_WR_WS,
      MEM_CLR
   } mem_op_type;

   typedef struct packed {
      logic        capture;
      logic        mod_start;
      mod_src_type mod_src;
      logic        lpw_load;
      logic        ws_mod_load;
      logic        ws_next_load;
      logic        beg_load;
      logic        beg_step;
      mem_op_type  mem_op;
      logic        attempt_apply;
      logic        qdone_load;
      logic        mark_apply;
      logic        restart_apply;
      logic        rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     mod_done;
      logic     exec_ok;
      logic     scan_more;
      logic     clr_last;
      logic     rsp_free;
      func_type func;
   } ctrl_stat_type;

   function automatic int idx_w_f(int m);
      return (m > 1) ? $clog2(m) : 1;
   endfunction

   function automatic int cnt_w_f(int m);
      return $clog2(m + 1);
   endfunction

   function automatic int val_w_f(int m);
      return (idx_w_f(m) + 1 > 13) ? idx_w_f(m) + 1 : 13;
   endfunction

   function automatic int beg_w_f(int m);
      return ((cnt_w_f(m) > 12) ? cnt_w_f(m) : 12) + 2;
   endfunction

endpackage

// ===== src/ring_order_completion_tracker_unit.sv =====
`timescale 1ns / 1ps

// Tracks in-order execution of the slabs of a ring with one done mark per slab held in a
// single-port memory, a last-executed pointer and saturating counters. Items are taken
// one at a time; every accepted item gives exactly one result item. Each item first
// reduces the last pointer modulo the ring size in a shift-subtract unit, which skips
// the shift-subtract loop when the magnitude of the value is below the ring size and
// runs it over every bit of the value otherwise; slab indices are reduced the same way.
// An attempt then reads and checks the done mark of the slab after the last pointer;
// a mark-to-repeat or a force-done writes the done mark of its slab. A query reduces
// three values, reads the done mark of its slab and then scans backward over the done
// slabs before a final check. Restart and reset run a clearing pass over all MAX_SLABS
// done marks, one per cycle, during which no item is accepted; configuration writes
// are always taken and should be made while idle. The result register lets the next
// item be accepted while a result waits to be taken; a result held by a stall holds
// the next one.

module ring_order_completion_tracker_unit #(
   parameter int MAX_SLABS = rocu_pkg::DEF_MAX_SLABS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic        [rocu_pkg::FUNC_W-1:0]      req_func,
   input  logic signed [rocu_pkg::SLAB_W-1:0]      req_slab,
   input  logic                                    req_ready_req,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_attempted,
   output logic                                    rsp_executed,
   output logic        [rocu_pkg::SLAB_OUT_W-1:0]  rsp_slab_out,
   output logic                                    rsp_slab_done,
   output logic signed [rocu_pkg::BEGIN_W-1:0]     rsp_range_begin,
   output logic        [rocu_pkg::REPORT_W-1:0]    rsp_executed_count,
   output logic        [rocu_pkg::ACTION_W-1:0]    rsp_raw_count,
   output logic                                    rsp_all_done,
   output logic                                    rsp_all_done_total,
   output logic        [rocu_pkg::SLAB_OUT_W-1:0]  rsp_last_slab,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [rocu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rocu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rocu_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rocu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   rocu_dp #(
      .MAX_SLABS(MAX_SLABS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_slab          (req_slab),
      .req_ready_req     (req_ready_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_attempted     (rsp_attempted),
      .rsp_executed      (rsp_executed),
      .rsp_slab_out      (rsp_slab_out),
      .rsp_slab_done     (rsp_slab_done),
      .rsp_range_begin   (rsp_range_begin),
      .rsp_executed_count(rsp_executed_count),
      .rsp_raw_count     (rsp_raw_count),
      .rsp_all_done      (rsp_all_done),
      .rsp_all_done_total(rsp_all_done_total),
      .rsp_last_slab     (rsp_last_slab),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

// ===== src/rocu_mod.sv =====
`timescale 1ns / 1ps

module rocu_mod #(
   parameter int MAX_SLABS = rocu_pkg::DEF_MAX_SLABS,
   localparam int IDX_W = rocu_pkg::idx_w_f(MAX_SLABS),
   localparam int CNT_W = rocu_pkg::cnt_w_f(MAX_SLABS),
   localparam int VAL_W = rocu_pkg::val_w_f(MAX_SLABS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VAL_W-1:0] value,
   input  logic        [CNT_W-1:0] n,
   output logic                    done,
   output logic        [IDX_W-1:0] result
);
   import rocu_pkg::*;

   localparam int MW = (VAL_W > CNT_W) ? VAL_W : CNT_W;
   localparam int CW = $clog2(VAL_W + 1);

   mod_state_type    state_ff, state_in;
   logic [CW-1:0]    cnt_ff;
   logic [VAL_W-1:0] mag_ff;
   logic [CNT_W-1:0] rem_ff;
   logic             neg_ff;

   logic [VAL_W-1:0] mag_in;
   logic             fits;
   logic [CNT_W:0]   r2;
   logic [CNT_W:0]   r2_sub;
   logic [CNT_W-1:0] fixed;

   always_comb begin
      mag_in = value[VAL_W-1] ? unsigned'(-value) : unsigned'(value);
      fits   = MW'(mag_in) < MW'(n);
      r2     = {rem_ff, mag_ff[VAL_W-1]};
      r2_sub = (r2 >= (CNT_W+1)'(n)) ? r2 - (CNT_W+1)'(n) : r2;
      fixed  = (neg_ff && rem_ff != '0) ? n - rem_ff : rem_ff;
   end

   always_comb begin
      state_in = state_ff;
      if (start) begin
         state_in = fits ? MS_FIX : MS_RUN;
      end else begin
         unique case (state_ff)
            MS_IDLE: state_in = MS_IDLE;
            MS_RUN:  state_in = (cnt_ff == CW'(1)) ? MS_FIX : MS_RUN;
            MS_FIX:  state_in = MS_IDLE;
            default: state_in = MS_IDLE;
         endcase
      end
   end

   always_comb begin
      done   = (state_ff == MS_FIX);
      result = IDX_W'(fixed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= value[VAL_W-1];
         mag_ff <= mag_in;
         cnt_ff <= CW'(VAL_W);
         rem_ff <= fits ? CNT_W'(mag_in) : '0;
      end else if (state_ff == MS_RUN) begin
         rem_ff <= CNT_W'(r2_sub);
         mag_ff <= mag_ff << 1;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

endmodule

// ===== src/rocu_dp.sv =====
`timescale 1ns / 1ps

module rocu_dp #(
   parameter int MAX_SLABS = rocu_pkg::DEF_MAX_SLABS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  rocu_pkg::ctrl_cmd_type                     cmd,
   output rocu_pkg::ctrl_stat_type                    stat,
   input  logic        [rocu_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [rocu_pkg::SLAB_W-1:0]         req_slab,
   input  logic                                       req_ready_req,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_attempted,
   output logic                                       rsp_executed,
   output logic        [rocu_pkg::SLAB_OUT_W-1:0]     rsp_slab_out,
   output logic                                       rsp_slab_done,
   output logic signed [rocu_pkg::BEGIN_W-1:0]        rsp_range_begin,
   output logic        [rocu_pkg::REPORT_W-1:0]       rsp_executed_count,
   output logic        [rocu_pkg::ACTION_W-1:0]       rsp_raw_count,
   output logic                                       rsp_all_done,
   output logic                                       rsp_all_done_total,
   output logic        [rocu_pkg::SLAB_OUT_W-1:0]     rsp_last_slab,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [rocu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic        [rocu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rocu_pkg::*;

   localparam int IDX_W  = idx_w_f(MAX_SLABS);
   localparam int CNT_W  = cnt_w_f(MAX_SLABS);
   localparam int VAL_W  = val_w_f(MAX_SLABS);
   localparam int BEG_W  = beg_w_f(MAX_SLABS);
   localparam int EXT_W  = (CNT_W > SC_W) ? CNT_W : SC_W;
   localparam int RST_N  = (MAX_SLABS < RESET_SLAB_COUNT) ? MAX_SLABS : RESET_SLAB_COUNT;
   localparam logic [IDX_W-1:0] LP_RESET = IDX_W'(RST_N - 1);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_SLABS - 1);
   localparam logic signed [VAL_W-1:0] ONE_V = 1;
   localparam logic signed [BEG_W-1:0] ONE_B = 1;

   // configuration
   logic [SC_W-1:0]     slab_count_ff;
   logic [START_W-1:0]  start_ff;
   logic [REPORT_W-1:0] expected_ff;

   // ring state
   logic                done_mem [MAX_SLABS];
   logic [IDX_W-1:0]    last_ptr_ff;
   logic [REPORT_W-1:0] report_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [IDX_W-1:0]    clr_ff;

   // working registers
   func_type                func_ff;
   logic signed [SLAB_W-1:0] slab_ff;
   logic                    ready_ff;
   logic [IDX_W-1:0]        lp_w_ff;
   logic [IDX_W-1:0]        ws_ff;
   logic [IDX_W-1:0]        wb_ff;
   logic signed [BEG_W-1:0] begin_ff;
   logic                    rd_ff;
   logic                    attempted_ff;
   logic                    executed_ff;
   logic                    qdone_ff;

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_attempted_ff;
   logic                     rsp_executed_ff;
   logic [SLAB_OUT_W-1:0]    rsp_slab_out_ff;
   logic                     rsp_slab_done_ff;
   logic signed [BEGIN_W-1:0] rsp_begin_ff;
   logic [REPORT_W-1:0]      rsp_report_ff;
   logic [ACTION_W-1:0]      rsp_action_ff;
   logic                     rsp_all_done_ff;
   logic                     rsp_all_total_ff;
   logic [SLAB_OUT_W-1:0]    rsp_last_ff;

   logic [EXT_W-1:0]         sc_ext;
   logic [CNT_W-1:0]         n;
   logic signed [VAL_W-1:0]  slab_x;
   logic signed [VAL_W-1:0]  mod_val;
   logic                     mod_done;
   logic [IDX_W-1:0]         mod_res;
   logic [CNT_W-1:0]         nx;
   logic [IDX_W-1:0]         ws_next;
   logic [IDX_W-1:0]         wb_dec;
   logic signed [BEG_W:0]    diff;
   logic signed [BEG_W:0]    n_s;
   logic                     exec_ok;
   logic [IDX_W-1:0]         mem_addr;
   logic                     mem_we;
   logic                     mem_wdata;
   logic                     rsp_take;

   always_comb begin
      sc_ext = EXT_W'(slab_count_ff);
      if (sc_ext == '0) begin
         n = CNT_W'(1);
      end else if (sc_ext > EXT_W'(MAX_SLABS)) begin
         n = CNT_W'(MAX_SLABS);
      end else begin
         n = CNT_W'(sc_ext);
      end
   end

   always_comb begin
      slab_x = VAL_W'(slab_ff);
      case (cmd.mod_src)
         SRC_LP:       mod_val = signed'(VAL_W'(last_ptr_ff));
         SRC_SLAB:     mod_val = slab_x;
         SRC_SLAB_M1:  mod_val = slab_x - ONE_V;
         SRC_START_M1: mod_val = signed'(VAL_W'(start_ff)) - ONE_V;
         default:      mod_val = slab_x;
      endcase
   end

   rocu_mod #(
      .MAX_SLABS(MAX_SLABS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mod_start),
      .value (mod_val),
      .n     (n),
      .done  (mod_done),
      .result(mod_res)
   );

   always_comb begin
      nx      = CNT_W'(mod_res) + CNT_W'(1);
      ws_next = (nx == n) ? '0 : IDX_W'(nx);
      wb_dec  = (wb_ff == '0) ? IDX_W'(n - CNT_W'(1)) : wb_ff - IDX_W'(1);
      diff    = (BEG_W+1)'(slab_ff) - (BEG_W+1)'(begin_ff);
      n_s     = signed'((BEG_W+1)'(n));
      exec_ok = !rd_ff && ready_ff;
   end

   // done marks memory
   always_comb begin
      unique case (cmd.mem_op)
         MEM_RD_WB: mem_addr = wb_ff;
         MEM_CLR:   mem_addr = clr_ff;
         default:   mem_addr = ws_ff;
      endcase
      mem_we    = (cmd.mem_op == MEM_WR_WS) || (cmd.mem_op == MEM_CLR);
      mem_wdata = (cmd.mem_op == MEM_WR_WS) && (func_ff != FN_MARK);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         done_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= done_mem[mem_addr];
   end

   // configuration and ring control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slab_count_ff <= SC_W'(RESET_SLAB_COUNT);
         start_ff      <= START_W'(RESET_START_SLAB);
         expected_ff   <= REPORT_W'(RESET_EXPECTED_TOTAL);
         last_ptr_ff   <= LP_RESET;
         report_ff     <= '0;
         action_ff     <= '0;
         clr_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SLAB_COUNT:     slab_count_ff <= SC_W'(csr_wdata);
               CSR_START_SLAB:     start_ff      <= START_W'(csr_wdata);
               CSR_EXPECTED_TOTAL: expected_ff   <= REPORT_W'(csr_wdata);
               default: ;
            endcase
         end
         if (cmd.mem_op == MEM_CLR) begin
            clr_ff <= (clr_ff == CLR_LAST) ? '0 : clr_ff + IDX_W'(1);
         end
         if (cmd.attempt_apply && exec_ok) begin
            last_ptr_ff <= ws_ff;
            if (report_ff != REPORT_MAX) report_ff <= report_ff + REPORT_W'(1);
            if (action_ff != ACTION_MAX) action_ff <= action_ff + ACTION_W'(1);
         end
         if (cmd.mark_apply) begin
            if (func_ff == FN_MARK) begin
               if (report_ff != '0) report_ff <= report_ff - REPORT_W'(1);
            end else begin
               if (report_ff != REPORT_MAX) report_ff <= report_ff + REPORT_W'(1);
            end
         end
         if (cmd.restart_apply) begin
            last_ptr_ff <= mod_res;
            report_ff   <= '0;
            action_ff   <= '0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff      <= func_type'(req_func);
         slab_ff      <= req_slab;
         ready_ff     <= req_ready_req;
         attempted_ff <= 1'b0;
         executed_ff  <= 1'b0;
         qdone_ff     <= 1'b0;
      end
      if (cmd.lpw_load) lp_w_ff <= mod_res;
      if (cmd.ws_mod_load) ws_ff <= mod_res;
      if (cmd.ws_next_load) ws_ff <= ws_next;
      if (cmd.qdone_load) qdone_ff <= rd_ff;
      if (cmd.beg_load) begin
         begin_ff <= signed'(BEG_W'(mod_res));
         wb_ff    <= mod_res;
      end
      if (cmd.beg_step) begin
         begin_ff <= begin_ff - ONE_B;
         wb_ff    <= wb_dec;
      end
      if (cmd.attempt_apply) begin
         attempted_ff <= !rd_ff;
         executed_ff  <= exec_ok;
         if (exec_ok) lp_w_ff <= ws_ff;
      end
      if (cmd.restart_apply) lp_w_ff <= mod_res;
   end

   // result register
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_attempted_ff <= attempted_ff;
         rsp_executed_ff  <= executed_ff;
         rsp_slab_out_ff  <= (func_ff == FN_ATTEMPT) ? SLAB_OUT_W'(ws_ff) : '0;
         rsp_slab_done_ff <= qdone_ff;
         rsp_begin_ff     <= (func_ff == FN_QUERY) ? BEGIN_W'(begin_ff) : '0;
         rsp_report_ff    <= report_ff;
         rsp_action_ff    <= action_ff;
         rsp_all_done_ff  <= (EXT_W'(report_ff) == EXT_W'(n));
         rsp_all_total_ff <= (report_ff == expected_ff);
         rsp_last_ff      <= SLAB_OUT_W'(lp_w_ff);
      end
   end

   always_comb begin
      rsp_valid          = rsp_valid_ff;
      rsp_attempted      = rsp_attempted_ff;
      rsp_executed       = rsp_executed_ff;
      rsp_slab_out       = rsp_slab_out_ff;
      rsp_slab_done      = rsp_slab_done_ff;
      rsp_range_begin    = rsp_begin_ff;
      rsp_executed_count = rsp_report_ff;
      rsp_raw_count      = rsp_action_ff;
      rsp_all_done       = rsp_all_done_ff;
      rsp_all_done_total = rsp_all_total_ff;
      rsp_last_slab      = rsp_last_ff;
      csr_ready          = 1'b1;
   end

   always_comb begin
      stat.mod_done  = mod_done;
      stat.exec_ok   = exec_ok;
      stat.scan_more = rd_ff && (diff < n_s);
      stat.clr_last  = (clr_ff == CLR_LAST);
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
      stat.func      = func_ff;
   end

endmodule

// ===== src/rocu_ctrl.sv =====
`timescale 1ns / 1ps

module rocu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rocu_pkg::ctrl_stat_type stat,
   output rocu_pkg::ctrl_cmd_type  cmd
);
   import rocu_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LP_WAIT;
         end
         ST_LP_WAIT: begin
            if (stat.mod_done) begin
               unique case (stat.func) inside
                  FN_ATTEMPT:                  state_in = ST_ATT_RD;
                  FN_QUERY, FN_MARK, FN_FORCE: state_in = ST_WS_WAIT;
                  FN_RESTART:                  state_in = ST_R_WAIT;
                  default:                     state_in = ST_RESP;
               endcase
            end
         end
         ST_ATT_RD:  state_in = ST_ATT_CHK;
         ST_ATT_CHK: state_in = ST_RESP;
         ST_WS_WAIT: begin
            if (stat.mod_done) begin
               state_in = (stat.func == FN_QUERY) ? ST_Q_RD : ST_M_WR;
            end
         end
         ST_Q_RD:   state_in = ST_Q_DONE;
         ST_Q_DONE: state_in = ST_Q_B0_WAIT;
         ST_Q_B0_WAIT: begin
            if (stat.mod_done) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            state_in = stat.scan_more ? ST_SCAN_RD : ST_RESP;
         end
         ST_M_WR: state_in = ST_RESP;
         ST_R_WAIT: begin
            if (stat.mod_done) state_in = ST_RCLEAR;
         end
         ST_RCLEAR: begin
            if (stat.clr_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mod_src = SRC_LP;
      cmd.mem_op  = MEM_NONE;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: cmd.mem_op = MEM_CLR;
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.mod_start = 1'b1;
               cmd.mod_src   = SRC_LP;
            end
         end
         ST_LP_WAIT: begin
            if (stat.mod_done) begin
               cmd.lpw_load = 1'b1;
               unique case (stat.func) inside
                  FN_ATTEMPT: cmd.ws_next_load = 1'b1;
                  FN_QUERY, FN_MARK, FN_FORCE: begin
                     cmd.mod_start = 1'b1;
                     cmd.mod_src   = SRC_SLAB;
                  end
                  FN_RESTART: begin
                     cmd.mod_start = 1'b1;
                     cmd.mod_src   = SRC_START_M1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ATT_RD: cmd.mem_op = MEM_RD_WS;
         ST_ATT_CHK: begin
            cmd.attempt_apply = 1'b1;
            if (stat.exec_ok) cmd.mem_op = MEM_WR_WS;
         end
         ST_WS_WAIT: begin
            if (stat.mod_done) cmd.ws_mod_load = 1'b1;
         end
         ST_Q_RD: cmd.mem_op = MEM_RD_WS;
         ST_Q_DONE: begin
            cmd.qdone_load = 1'b1;
            cmd.mod_start  = 1'b1;
            cmd.mod_src    = SRC_SLAB_M1;
         end
         ST_Q_B0_WAIT: begin
            if (stat.mod_done) cmd.beg_load = 1'b1;
         end
         ST_SCAN_RD: cmd.mem_op = MEM_RD_WB;
         ST_SCAN_CHK: begin
            if (stat.scan_more) cmd.beg_step = 1'b1;
         end
         ST_M_WR: begin
            cmd.mem_op     = MEM_WR_WS;
            cmd.mark_apply = 1'b1;
         end
         ST_R_WAIT: begin
            if (stat.mod_done) cmd.restart_apply = 1'b1;
         end
         ST_RCLEAR: cmd.mem_op = MEM_CLR;
         ST_RESP: begin
            if (stat.rsp_free) cmd.rsp_load = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== tb/ring_status_checker.sv =====
`timescale 1ns / 1ps

module ring_status_checker #(
   parameter int MAX_SLABS = rocu_pkg::DEF_MAX_SLABS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic        [rocu_pkg::FUNC_W-1:0]      req_func,
   input  logic signed [rocu_pkg::SLAB_W-1:0]      req_slab,
   input  logic                                    req_ready_req,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic                                    rsp_attempted,
   input  logic                                    rsp_executed,
   input  logic        [rocu_pkg::SLAB_OUT_W-1:0]  rsp_slab_out,
   input  logic                                    rsp_slab_done,
   input  logic signed [rocu_pkg::BEGIN_W-1:0]     rsp_range_begin,
   input  logic        [rocu_pkg::REPORT_W-1:0]    rsp_executed_count,
   input  logic        [rocu_pkg::ACTION_W-1:0]    rsp_raw_count,
   input  logic                                    rsp_all_done,
   input  logic                                    rsp_all_done_total,
   input  logic        [rocu_pkg::SLAB_OUT_W-1:0]  rsp_last_slab,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic        [rocu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rocu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                      fail_count,
   output int                                      pending_count
);

   import rocu_pkg::*;

   typedef struct packed {
      logic                      attempted;
      logic                      executed;
      logic [SLAB_OUT_W-1:0]     slab_out;
      logic                      slab_done;
      logic signed [BEGIN_W-1:0] range_begin;
      logic [REPORT_W-1:0]       executed_count;
      logic [ACTION_W-1:0]       raw_count;
      logic                      all_done;
      logic                      all_done_total;
      logic [SLAB_OUT_W-1:0]     last_slab;
   } ring_status_type;

   ring_status_type status_q[$];

   logic [SC_W-1:0]     cfg_slab_count;
   logic [START_W-1:0]  cfg_start_slab;
   logic [REPORT_W-1:0] cfg_expected_total;

   bit                  slab_marks[MAX_SLABS];
   int                  last_ptr;
   logic [REPORT_W-1:0] report_count;
   logic [ACTION_W-1:0] action_count;

   function automatic int ring_len();
      int n;
      n = cfg_slab_count;
      if (n < 1) n = 1;
      if (n > MAX_SLABS) n = MAX_SLABS;
      return n;
   endfunction

   function automatic int wrap_slab(input int s);
      int n;
      int r;
      n = ring_len();
      r = s % n;
      if (r < 0) r = r + n;
      return r;
   endfunction

   task automatic restart_ring();
      foreach (slab_marks[i]) slab_marks[i] = 1'b0;
      report_count = '0;
      action_count = '0;
      last_ptr = wrap_slab(int'(cfg_start_slab) - 1);
   endtask

   task automatic predict_status(input logic [FUNC_W-1:0] fn,
                                 input logic signed [SLAB_W-1:0] slab_in,
                                 input logic rdy);
      ring_status_type st;
      int n;
      int s;
      int ws;
      int beg;
      st = '0;
      n = ring_len();
      s = slab_in;
      case (fn)
         FN_ATTEMPT: begin
            ws = wrap_slab(wrap_slab(last_ptr) + 1);
            st.slab_out = ws[SLAB_OUT_W-1:0];
            if (!slab_marks[ws]) begin
               st.attempted = 1'b1;
               if (rdy) begin
                  st.executed = 1'b1;
                  slab_marks[ws] = 1'b1;
                  last_ptr = ws;
                  if (report_count != REPORT_MAX) report_count = report_count + 1'b1;
                  if (action_count != ACTION_MAX) action_count = action_count + 1'b1;
               end
            end
         end
         FN_QUERY: begin
            st.slab_done = slab_marks[wrap_slab(s)];
            beg = wrap_slab(s - 1);
            while (slab_marks[wrap_slab(beg)] && (s - beg) < n) beg = beg - 1;
            st.range_begin = beg[BEGIN_W-1:0];
         end
         FN_MARK: begin
            slab_marks[wrap_slab(s)] = 1'b0;
            if (report_count != '0) report_count = report_count - 1'b1;
         end
         FN_FORCE: begin
            slab_marks[wrap_slab(s)] = 1'b1;
            if (report_count != REPORT_MAX) report_count = report_count + 1'b1;
         end
         FN_RESTART: begin
            restart_ring();
         end
         default: ;
      endcase
      st.executed_count = report_count;
      st.raw_count = action_count;
      st.all_done = (int'(report_count) == n);
      st.all_done_total = (report_count == cfg_expected_total);
      st.last_slab = SLAB_OUT_W'(wrap_slab(last_ptr));
      status_q.push_back(st);
   endtask

   task automatic report_error(input string msg);
      fail_count = fail_count + 1;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      ring_status_type want;
      if (reset) begin
         cfg_slab_count = SC_W'(RESET_SLAB_COUNT);
         cfg_start_slab = START_W'(RESET_START_SLAB);
         cfg_expected_total = REPORT_W'(RESET_EXPECTED_TOTAL);
         restart_ring();
         status_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report_error("result item with no command outstanding");
            end else begin
               want = status_q.pop_front();
               check_field("attempted", rsp_attempted, want.attempted);
               check_field("executed", rsp_executed, want.executed);
               check_field("slab_out", rsp_slab_out, want.slab_out);
               check_field("slab_done", rsp_slab_done, want.slab_done);
               check_field("range_begin", rsp_range_begin, want.range_begin);
               check_field("executed_count", rsp_executed_count, want.executed_count);
               check_field("raw_count", rsp_raw_count, want.raw_count);
               check_field("all_done", rsp_all_done, want.all_done);
               check_field("all_done_total", rsp_all_done_total, want.all_done_total);
               check_field("last_slab", rsp_last_slab, want.last_slab);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLAB_COUNT:     cfg_slab_count = csr_wdata;
               CSR_START_SLAB:     cfg_start_slab = csr_wdata[START_W-1:0];
               CSR_EXPECTED_TOTAL: cfg_expected_total = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_status(req_func, req_slab, req_ready_req);
      end
      pending_count = status_q.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   import rocu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 2 * DEF_MAX_SLABS + 64;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 100;
   localparam int FORCE_ITEMS    = 700;
   localparam int SC_TOP         = (1 << SC_W) - 1;
   localparam int START_TOP      = (1 << START_W) - 1;
   localparam int SLAB_TOP       = (1 << SLAB_W) - 1;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic        [FUNC_W-1:0]    req_func = '0;
   logic signed [SLAB_W-1:0]    req_slab = '0;
   logic                        req_ready_req = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_attempted;
   logic                        rsp_executed;
   logic        [SLAB_OUT_W-1:0] rsp_slab_out;
   logic                        rsp_slab_done;
   logic signed [BEGIN_W-1:0]   rsp_range_begin;
   logic        [REPORT_W-1:0]  rsp_executed_count;
   logic        [ACTION_W-1:0]  rsp_raw_count;
   logic                        rsp_all_done;
   logic                        rsp_all_done_total;
   logic        [SLAB_OUT_W-1:0] rsp_last_slab;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_SLAB_COUNT;
   logic        [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int quiet_cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   ring_order_completion_tracker_unit u_top (.*);

   ring_status_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(4, 48);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic issue(input logic [FUNC_W-1:0] fn, input int s, input logic rdy);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= fn;
      req_slab <= s[SLAB_W-1:0];
      req_ready_req <= rdy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input csr_index_type idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int sc, input int first, input int total);
      write_reg(CSR_SLAB_COUNT, sc);
      write_reg(CSR_START_SLAB, first);
      write_reg(CSR_EXPECTED_TOTAL, total);
   endtask

   task automatic random_command(input int n);
      int pick;
      int s;
      logic [FUNC_W-1:0] fn;
      pick = $urandom_range(0, 99);
      if (pick < 55) fn = FN_ATTEMPT;
      else if (pick < 72) fn = FN_QUERY;
      else if (pick < 82) fn = FN_MARK;
      else if (pick < 92) fn = FN_FORCE;
      else if (pick < 95) fn = FN_RESTART;
      else fn = FUNC_W'(FN_RESTART + $urandom_range(1, 3));
      pick = $urandom_range(0, 9);
      if (pick < 6) s = $urandom_range(0, n - 1);
      else if (pick < 8) s = int'($urandom_range(0, 4 * n)) - 2 * n;
      else s = $urandom_range(0, SLAB_TOP);
      issue(fn, s, $urandom_range(0, 99) < 80);
   endtask

   initial begin : stimulus
      int sc;
      int first;
      int total;
      int n;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: ring of 1024 starting at slab 0
      issue(FN_QUERY, 0, 1'b0);
      issue(FN_ATTEMPT, 0, 1'b0);
      issue(FN_ATTEMPT, 0, 1'b1);
      issue(FN_ATTEMPT, 0, 1'b1);
      issue(FN_FORCE, 3, 1'b1);
      issue(FN_ATTEMPT, 0, 1'b1);
      issue(FN_ATTEMPT, 0, 1'b1);
      issue(FN_QUERY, 4, 1'b0);
      issue(FN_QUERY, SLAB_TOP >> 1, 1'b1);
      issue(FN_QUERY, -(SLAB_TOP + 1) / 2, 1'b1);
      issue(FN_QUERY, -1, 1'b0);
      issue(FN_MARK, 1, 1'b0);
      issue(FN_MARK, -(SLAB_TOP + 1) / 2, 1'b1);
      issue(FN_MARK, SLAB_TOP >> 1, 1'b0);
      issue(FN_FORCE, -1, 1'b0);
      issue(FN_QUERY, 0, 1'b1);
      issue(FN_ATTEMPT, SLAB_TOP >> 1, 1'b1);
      issue(FUNC_W'(FN_RESTART + 1), 7, 1'b1);
      issue(FUNC_W'(FN_RESTART + 2), -5, 1'b0);
      issue(FUNC_W'(FN_RESTART + 3), SLAB_TOP, 1'b1);
      issue(FN_RESTART, 0, 1'b0);
      issue(FN_MARK, 5, 1'b0);
      issue(FN_ATTEMPT, 0, 1'b1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin sc = 1; first = 0; total = 0; end
            1: begin sc = 0; first = START_TOP; total = 1; end
            2: begin sc = SC_TOP; first = START_TOP; total = SC_TOP; end
            3: begin sc = DEF_MAX_SLABS + 1; first = 512; total = DEF_MAX_SLABS; end
            4: begin sc = 5; first = 3; total = 5; end
            5: begin sc = 16; first = START_TOP; total = 10; end
            6: begin sc = 3; first = $urandom_range(0, START_TOP); total = 2; end
            7: begin sc = 64; first = $urandom_range(0, START_TOP); total = $urandom_range(0, 64); end
            8: begin
               sc = RESET_SLAB_COUNT;
               first = RESET_START_SLAB;
               total = RESET_EXPECTED_TOTAL;
            end
            default: begin
               sc = $urandom_range(1, 100);
               first = $urandom_range(0, START_TOP);
               total = $urandom_range(0, sc);
            end
         endcase
         configure(sc, first, total);
         n = (sc < 1) ? 1 : ((sc > DEF_MAX_SLABS) ? DEF_MAX_SLABS : sc);
         // phase 6 keeps the pointer left over from the larger ring
         if (phase != 6 && $urandom_range(0, 1) == 1) issue(FN_RESTART, 0, 1'b0);
         repeat (PHASE_ITEMS) random_command(n);
         wait_drained();
      end

      // long run of force-done items on a small ring, passing the expected total
      configure(4, 2, FORCE_ITEMS / 2);
      issue(FN_RESTART, 0, 1'b0);
      repeat (FORCE_ITEMS) issue(FN_FORCE, $urandom_range(0, SLAB_TOP), 1'($urandom_range(0, 1)));
      repeat (20) random_command(4);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
